/* hdl/relb_pkg.sv */
// ----------------------------------------------------------------------------
// Relocation block parser package
// Types and constants shared by the relocation block parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package relb_pkg;

  // Widths of the directory words and of the parse state.
  localparam int unsigned HalfWidth   = 16;
  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned SizeWidth   = 32;
  localparam int unsigned CountWidth  = 31;
  localparam int unsigned TotalWidth  = 33;
  localparam int unsigned OffsetWidth = 12;
  localparam int unsigned KindWidth   = 4;

  // Entry type codes, taken from the top four bits of an entry word.
  localparam logic [KindWidth-1:0] KIND_LOW  = 4'd3;
  localparam logic [KindWidth-1:0] KIND_WIDE = 4'd10;

  // Size of a block header in bytes.
  localparam logic [SizeWidth-1:0] HEADER_BYTES = 32'd8;

  // Position within a block: the four header words, then the entries.
  typedef enum logic [2:0] {
    PH_PAGE_LO = 3'd0,
    PH_PAGE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_ENTRY   = 3'd4
  } relb_phase_e;

  // One result word as it leaves the parser.
  typedef struct packed {
    logic                 has_target;
    logic [AddrWidth-1:0] target_address;
    logic                 is_wide;
    logic                 done_res;
    logic                 malformed;
  } relb_result_t;

endpackage

`default_nettype wire

/* hdl/pe_relocation_block_parser_unit.sv */
// ----------------------------------------------------------------------------
// PE base relocation block parser
// Takes the relocation directory one 16-bit word per cycle and gives one
// result word per input word: a target address for each type 3 or type 10
// entry, plus sticky done and malformed flags. A word passes through an input
// register, the parse logic and a result register; a new word is taken every
// cycle while results are taken. The directory size register applies at the
// next block boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_relocation_block_parser_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [relb_pkg::SizeWidth-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [relb_pkg::HalfWidth-1:0] halfword_i,
  input  wire logic                           first_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                has_target_o,
  output logic [relb_pkg::AddrWidth-1:0]      target_address_o,
  output logic                                is_wide_o,
  output logic                                done_res_o,
  output logic                                malformed_o
);

  import relb_pkg::*;

  logic [SizeWidth-1:0] dir_bytes_q;
  logic                 stage_valid;
  logic [HalfWidth-1:0] stage_halfword;
  logic                 stage_first;
  logic                 out_free;
  logic                 advance;
  relb_result_t         step_result;
  relb_result_t         result_q;
  logic                 out_valid_q, out_valid_d;

  // Directory size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_bytes_q <= '0;
    end else if (cfg_we_i) begin
      dir_bytes_q <= cfg_wdata_i;
    end
  end

  // A word moves into the result register when that register is free.
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = stage_valid && out_free;

  relb_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .halfword_i (halfword_i),
    .first_i    (first_i),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .halfword_o (stage_halfword),
    .first_o    (stage_first)
  );

  relb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .halfword_i  (stage_halfword),
    .first_i     (stage_first),
    .dir_bytes_i (dir_bytes_q),
    .result_o    (step_result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign has_target_o     = result_q.has_target;
  assign target_address_o = result_q.target_address;
  assign is_wide_o        = result_q.is_wide;
  assign done_res_o       = result_q.done_res;
  assign malformed_o      = result_q.malformed;

  // A malformed block always ends the directory.
  a_malformed_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.malformed |-> result_q.done_res)
    else $error("malformed flag set without done");

  // No target can come from a directory already marked malformed.
  a_target_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.has_target |-> !result_q.malformed)
    else $error("target reported in a malformed directory");

  // Words without a target carry a cleared address and width flag.
  a_no_target_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.has_target |->
      (result_q.target_address == '0) && !result_q.is_wide)
    else $error("stray address on a word without a target");

  // The input side only stalls when both registers hold a word.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stage_valid && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* hdl/relb_in_reg.sv */
// ----------------------------------------------------------------------------
// Relocation block parser input register
// Holds one incoming directory word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module relb_in_reg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [relb_pkg::HalfWidth-1:0] halfword_i,
  input  wire logic                          first_i,
  input  wire logic                          take_i,
  output logic                               valid_o,
  output logic [relb_pkg::HalfWidth-1:0]     halfword_o,
  output logic                               first_o
);

  import relb_pkg::*;

  logic                 valid_q, valid_d;
  logic [HalfWidth-1:0] halfword_q;
  logic                 first_q;

  // The register is free when empty or when its word moves on this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded with every accepted word.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      halfword_q <= halfword_i;
      first_q    <= first_i;
    end
  end

  assign valid_o    = valid_q;
  assign halfword_o = halfword_q;
  assign first_o    = first_q;

endmodule

`default_nettype wire

/* hdl/relb_core.sv */
// ----------------------------------------------------------------------------
// Relocation block parser core
// Keeps the parse state and works out the result for one directory word.
// ----------------------------------------------------------------------------
`default_nettype none

module relb_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic [relb_pkg::HalfWidth-1:0] halfword_i,
  input  wire logic                           first_i,
  input  wire logic [relb_pkg::SizeWidth-1:0] dir_bytes_i,
  output relb_pkg::relb_result_t              result_o
);

  import relb_pkg::*;

  relb_phase_e           phase_q, phase_d, eff_phase;
  logic [AddrWidth-1:0]  page_q, page_d, eff_page;
  logic [SizeWidth-1:0]  block_q, block_d, eff_block;
  logic [CountWidth-1:0] entries_q, entries_d, eff_entries;
  logic [TotalWidth-1:0] total_q, total_d, eff_total;
  logic                  finished_q, finished_d, eff_finished;
  logic                  bad_q, bad_d, eff_bad;

  logic [SizeWidth-1:0]  size_full;
  logic [TotalWidth-1:0] total_sum;
  logic [TotalWidth-1:0] dir_ext;
  logic [KindWidth-1:0]  kind;
  logic                  hit;

  // A first word restarts the parse from the reset state.
  always_comb begin
    if (first_i) begin
      eff_phase    = PH_PAGE_LO;
      eff_page     = '0;
      eff_block    = '0;
      eff_entries  = '0;
      eff_total    = '0;
      eff_finished = 1'b0;
      eff_bad      = 1'b0;
    end else begin
      eff_phase    = phase_q;
      eff_page     = page_q;
      eff_block    = block_q;
      eff_entries  = entries_q;
      eff_total    = total_q;
      eff_finished = finished_q;
      eff_bad      = bad_q;
    end
  end

  assign size_full = {halfword_i, eff_block[HalfWidth-1:0]};
  assign total_sum = eff_total + {1'b0, size_full};
  assign dir_ext   = {1'b0, dir_bytes_i};

  // Next state of the parse.
  always_comb begin
    phase_d    = eff_phase;
    page_d     = eff_page;
    block_d    = eff_block;
    entries_d  = eff_entries;
    total_d    = eff_total;
    finished_d = eff_finished;
    bad_d      = eff_bad;
    if (!eff_finished) begin
      unique case (eff_phase)
        PH_PAGE_HI: begin
          page_d  = {halfword_i, eff_page[HalfWidth-1:0]};
          phase_d = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          block_d = {{(SizeWidth-HalfWidth){1'b0}}, halfword_i};
          phase_d = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          block_d = size_full;
          phase_d = PH_PAGE_LO;
          if (size_full == '0 && eff_page == '0) begin
            finished_d = 1'b1;
          end else if (size_full < HEADER_BYTES || size_full[0]) begin
            bad_d      = 1'b1;
            finished_d = 1'b1;
          end else begin
            // Entries follow at two bytes each after the header.
            entries_d = size_full[SizeWidth-1:1] - CountWidth'(HEADER_BYTES >> 1);
            total_d   = total_sum;
            if (size_full == HEADER_BYTES) begin
              finished_d = (total_sum >= dir_ext);
            end else begin
              phase_d = PH_ENTRY;
            end
          end
        end
        PH_ENTRY: begin
          entries_d = eff_entries - CountWidth'(1);
          if (entries_d == '0) begin
            phase_d    = PH_PAGE_LO;
            finished_d = (eff_total >= dir_ext);
          end
        end
        default: begin
          // Start of a block: stop once the directory size is used up.
          if (eff_total >= dir_ext) begin
            finished_d = 1'b1;
            phase_d    = PH_PAGE_LO;
          end else begin
            page_d  = {{(AddrWidth-HalfWidth){1'b0}}, halfword_i};
            phase_d = PH_PAGE_HI;
          end
        end
      endcase
    end
  end

  // Result of this word: an entry of a relocating type gives a target.
  assign kind = halfword_i[HalfWidth-1 -: KindWidth];

  always_comb begin
    hit = !eff_finished && (eff_phase == PH_ENTRY) &&
          ((kind == KIND_LOW) || (kind == KIND_WIDE));
    result_o.has_target     = hit;
    result_o.target_address = hit ?
      (eff_page + {{(AddrWidth-OffsetWidth){1'b0}}, halfword_i[OffsetWidth-1:0]}) : '0;
    result_o.is_wide        = hit && (kind == KIND_WIDE);
    result_o.done_res       = finished_d;
    result_o.malformed      = bad_d;
  end

  // State moves on with every word that is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PAGE_LO;
      page_q     <= '0;
      block_q    <= '0;
      entries_q  <= '0;
      total_q    <= '0;
      finished_q <= 1'b0;
      bad_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      page_q     <= page_d;
      block_q    <= block_d;
      entries_q  <= entries_d;
      total_q    <= total_d;
      finished_q <= finished_d;
      bad_q      <= bad_d;
    end
  end

endmodule

`default_nettype wire
